// File: design/r2p_pkg.sv
package r2p_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int ITERATIONS = 16;
    localparam int GUARD_BITS = 8;
    localparam int ANGLE_FRAC = 30;
    localparam int TABLE_LEN  = 24;

    localparam int CORDIC_STEPS = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    localparam int SQRT_STEPS   = DATA_WIDTH;
    localparam int NSTAGE       = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int IDXW         = (NSTAGE > 1) ? $clog2(NSTAGE) : 1;

    // rotation datapath, angle accumulator, square root remainder/root
    localparam int XW = DATA_WIDTH + GUARD_BITS + 3;
    localparam int ZW = 34;
    localparam int SW = 2 * DATA_WIDTH + 1;

    localparam int TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

    localparam int PH_FRAC  = DATA_WIDTH - 3;
    localparam int PH_SHIFT = ANGLE_FRAC - PH_FRAC;

    localparam logic signed [ZW-1:0] PI_SCALED = 34'sd3373259426;
    localparam logic signed [ZW-1:0] PH_HALF   = ZW'(64'sd1 <<< (PH_SHIFT - 1));
    localparam logic signed [ZW-1:0] PH_LIM    = (PI_SCALED + PH_HALF) >>> PH_SHIFT;

    typedef struct packed {
        logic               zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [SW-1:0]        s;
        logic [SW-1:0]        r;
    } stage_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic signed [ZW-1:0] atan_coef(input int i);
        logic signed [ZW-1:0] c;
        case (i)
            0:       c = 34'sd843314856;
            1:       c = 34'sd497837829;
            2:       c = 34'sd263043836;
            3:       c = 34'sd133525158;
            4:       c = 34'sd67021686;
            5:       c = 34'sd33543515;
            6:       c = 34'sd16775850;
            7:       c = 34'sd8388437;
            8:       c = 34'sd4194282;
            9:       c = 34'sd2097149;
            10:      c = 34'sd1048575;
            11:      c = 34'sd524287;
            12:      c = 34'sd262143;
            13:      c = 34'sd131071;
            14:      c = 34'sd65535;
            15:      c = 34'sd32767;
            16:      c = 34'sd16383;
            17:      c = 34'sd8191;
            18:      c = 34'sd4095;
            19:      c = 34'sd2047;
            20:      c = 34'sd1023;
            21:      c = 34'sd511;
            22:      c = 34'sd255;
            23:      c = 34'sd127;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: design/r2p_stage.sv
module r2p_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic [r2p_pkg::IDXW-1:0]  idx,
    input  logic                      in_valid,
    input  r2p_pkg::stage_t           in_data,
    output logic                      out_valid,
    output r2p_pkg::stage_t           out_data
);
    import r2p_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    // one cordic micro-rotation and one restoring square root step
    always_comb begin : step_logic
        int                   k;
        int                   sq_shift;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] ang;
        logic [SW-1:0]        sq_bit;
        logic [SW-1:0]        trial;

        k         = int'(idx);
        data_next = in_data;
        x         = in_data.x;
        y         = in_data.y;
        dx        = y >>> idx;
        dy        = x >>> idx;
        ang       = atan_coef(k);
        sq_shift  = 0;
        sq_bit    = '0;
        trial     = '0;

        if (k < CORDIC_STEPS) begin
            if (!y[XW-1]) begin
                data_next.x = x + dx;
                data_next.y = y - dy;
                data_next.z = in_data.z + ang;
            end else begin
                data_next.x = x - dx;
                data_next.y = y + dy;
                data_next.z = in_data.z - ang;
            end
        end

        if (k < SQRT_STEPS) begin
            sq_shift = 2 * (SQRT_STEPS - 1 - k);
            sq_bit   = SW'(1) << sq_shift;
            trial    = in_data.r + sq_bit;
            if (in_data.s >= trial) begin
                data_next.s = in_data.s - trial;
                data_next.r = (in_data.r >> 1) + sq_bit;
            end else begin
                data_next.r = in_data.r >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: design/rect_to_polar_converter.sv
// rectangular to polar converter
//
// slave stream: one beat carries one complex sample, s_tdata = {imag, real},
// both two's complement, real in the low bits. master stream: one beat per
// sample, m_tdata = {phase, magnitude}; magnitude is the rounded integer
// square root of re^2 + im^2, phase is atan2(im, re) in radians, signed with
// DATA_WIDTH-3 fraction bits, clamped to +-pi. a zero input gives zero/zero.
//
// throughput is one beat per clock while the skid register is empty: each
// register stage does one cordic micro-rotation and one square root digit,
// and all stages move together. the accepting edge loads the input/multiply
// stage, then the sum stage, NSTAGE rotate/root stages and the output
// register follow, in that order, before m_tvalid rises.
//
// synchronous active-low reset empties the pipeline and the output side.
// when the receiver stalls, the output register holds its beat and a one-beat
// skid register catches the beat leaving the pipeline; only while the skid is
// full does the whole pipeline freeze and s_tready drop, so nothing is lost.
module rect_to_polar_converter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [r2p_pkg::TDATA_W-1:0]  s_tdata,   // imag_part, real_part
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [r2p_pkg::TDATA_W-1:0]  m_tdata    // phase, magnitude
);
    import r2p_pkg::*;

    // pipeline advance: frozen only while the skid register is occupied
    logic en;

    // input fields
    logic signed [DATA_WIDTH-1:0]   in_re;
    logic signed [DATA_WIDTH-1:0]   in_im;
    logic signed [2*DATA_WIDTH-1:0] prod_re;
    logic signed [2*DATA_WIDTH-1:0] prod_im;
    logic signed [XW-1:0]           x_ext;
    logic signed [XW-1:0]           y_ext;

    // first stage: squares and pre-rotated vector
    logic                     a_valid_reg;
    logic [2*DATA_WIDTH-1:0]  a_sq_re_reg;
    logic [2*DATA_WIDTH-1:0]  a_sq_im_reg;
    logic signed [XW-1:0]     a_x_reg;
    logic signed [XW-1:0]     a_y_reg;
    logic signed [ZW-1:0]     a_z_reg;
    logic                     a_zero_reg;
    logic signed [XW-1:0]     a_x_next;
    logic signed [XW-1:0]     a_y_next;
    logic signed [ZW-1:0]     a_z_next;

    // second stage feeds the rotate/root chain
    logic                     b_valid_reg;
    stage_t                   b_data_reg;
    stage_t                   b_data_next;

    logic   [NSTAGE:0]        pipe_valid;
    stage_t                   pipe_data [0:NSTAGE];

    // result formatting
    stage_t                   last;
    logic [SW-1:0]            mag_wide;
    logic signed [ZW-1:0]     z_round;
    logic signed [ZW-1:0]     ph_wide;
    logic signed [ZW-1:0]     ph_clamp;
    logic [TDATA_W-1:0]       res_data;

    // output register and skid
    logic                     out_valid_reg;
    logic [TDATA_W-1:0]       out_data_reg;
    logic                     skid_valid_reg;
    logic [TDATA_W-1:0]       skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    assign in_re   = s_tdata[DATA_WIDTH-1:0];
    assign in_im   = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign prod_re = in_re * in_re;
    assign prod_im = in_im * in_im;

    // guard bits below the input lsb, sign bits above for cordic growth
    assign x_ext = {{(XW-DATA_WIDTH-GUARD_BITS){in_re[DATA_WIDTH-1]}}, in_re,
                    {GUARD_BITS{1'b0}}};
    assign y_ext = {{(XW-DATA_WIDTH-GUARD_BITS){in_im[DATA_WIDTH-1]}}, in_im,
                    {GUARD_BITS{1'b0}}};

    // left half plane: rotate by pi so the cordic sees x >= 0
    always_comb begin
        a_x_next = x_ext;
        a_y_next = y_ext;
        a_z_next = '0;
        if (in_re[DATA_WIDTH-1]) begin
            a_x_next = -x_ext;
            a_y_next = -y_ext;
            a_z_next = in_im[DATA_WIDTH-1] ? -PI_SCALED : PI_SCALED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sq_re_reg <= prod_re;
            a_sq_im_reg <= prod_im;
            a_x_reg     <= a_x_next;
            a_y_reg     <= a_y_next;
            a_z_reg     <= a_z_next;
            a_zero_reg  <= (in_re == '0) && (in_im == '0);
            b_data_reg  <= b_data_next;
        end
    end

    // sum of squares starts the root with an empty result
    always_comb begin
        b_data_next.zero = a_zero_reg;
        b_data_next.x    = a_x_reg;
        b_data_next.y    = a_y_reg;
        b_data_next.z    = a_z_reg;
        b_data_next.s    = {1'b0, a_sq_re_reg} + {1'b0, a_sq_im_reg};
        b_data_next.r    = '0;
    end

    assign pipe_valid[0] = b_valid_reg;
    assign pipe_data[0]  = b_data_reg;

    // one stage per micro-rotation / root digit
    for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
        r2p_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .idx       (IDXW'(i)),
            .in_valid  (pipe_valid[i]),
            .in_data   (pipe_data[i]),
            .out_valid (pipe_valid[i+1]),
            .out_data  (pipe_data[i+1])
        );
    end

    // round the root half up, round and clamp the angle
    always_comb begin
        last     = pipe_data[NSTAGE];
        mag_wide = (last.s > last.r) ? last.r + SW'(1) : last.r;
        z_round  = last.z + PH_HALF;
        ph_wide  = z_round >>> PH_SHIFT;
        ph_clamp = ph_wide;
        if (ph_wide > PH_LIM) begin
            ph_clamp = PH_LIM;
        end else if (ph_wide < -PH_LIM) begin
            ph_clamp = -PH_LIM;
        end
        res_data = '0;
        if (!last.zero) begin
            res_data[DATA_WIDTH-1:0]            = mag_wide[DATA_WIDTH-1:0];
            res_data[2*DATA_WIDTH-1:DATA_WIDTH] = ph_clamp[DATA_WIDTH-1:0];
        end
    end

    // output register with skid: a waiting beat never blocks the pipeline
    // until a second one arrives behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_valid[NSTAGE]) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (pipe_valid[NSTAGE]) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= res_data;
            end else begin
                skid_data_reg <= res_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: design/r2p_checker.sv
module r2p_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [r2p_pkg::TDATA_W-1:0]  m_tdata
);
    import r2p_pkg::*;

    localparam logic signed [DATA_WIDTH-1:0] LIM = PH_LIM[DATA_WIDTH-1:0];

    logic [DATA_WIDTH-1:0]        mag;
    logic signed [DATA_WIDTH-1:0] ph;

    assign mag = m_tdata[DATA_WIDTH-1:0];
    assign ph  = m_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    // a stalled beat keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    // backpressure only with a beat waiting at the output
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // phase never leaves the clamp range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ph <= LIM) && (ph >= -LIM))
        else $error("phase out of range");

    // zero magnitude only comes from a zero sample
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (mag == '0) |-> (ph == '0))
        else $error("zero magnitude with nonzero phase");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind rect_to_polar_converter r2p_checker u_r2p_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
